// ===== hw/rtl/efcp_pkg.sv =====
`timescale 1ns / 1ps

package efcp_pkg;

	// Field widths fixed by the frame format.
	localparam int ANGLE_W  = 12;
	localparam int STATUS_W = 5;
	localparam int RETRY_W  = 3;
	localparam int CHK_W    = 17;

	// Status codes that mark a good frame.
	localparam logic [STATUS_W-1:0] STATUS_OK_A = 5'h10;
	localparam logic [STATUS_W-1:0] STATUS_OK_B = 5'h13;

	// Half a turn in angle counts.
	localparam logic [ANGLE_W-1:0] HALF_TURN = 12'd2048;

	// Reset value of the retry limit register.
	localparam logic [RETRY_W-1:0] RETRY_RESET = 3'd4;

	// One accepted sample handed from the front end to the back end.
	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               channel;
		logic               forced;
	} sample_t;

endpackage

// ===== hw/rtl/efcp_fifo.sv =====
`timescale 1ns / 1ps

module efcp_fifo
	import efcp_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sample_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    not_empty,
	output sample_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sample_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Storage for queued samples; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/efcp_front.sv =====
`timescale 1ns / 1ps

module efcp_front
	import efcp_pkg::*;
#(
	parameter int CHANNEL_COUNT = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [RETRY_W-1:0] retry_limit,
	input  logic               accept,
	input  logic [7:0]         frame_byte_hi,
	input  logic [7:0]         frame_byte_mid,
	input  logic [7:0]         frame_byte_lo,
	input  logic               channel,
	output logic               push,
	output sample_t            push_data
);

	localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic [RETRY_W-1:0]  reject_q [CHANNEL_COUNT];
	logic [CH_IDX_W-1:0] ch_idx;
	logic                ch_ok;
	logic [CHK_W-1:0]    checked;
	logic [STATUS_W-1:0] status;
	logic                parity_bit;
	logic                good;
	logic                forced_now;
	logic                take;

	// Unpack the frame: the checked word is bits 22 down to 6 of the three bytes.
	assign checked    = {frame_byte_hi[6:0], frame_byte_mid, frame_byte_lo[7:6]};
	assign status     = {frame_byte_mid[2:0], frame_byte_lo[7:6]};
	assign parity_bit = frame_byte_lo[5];

	assign ch_idx = CH_IDX_W'(channel);
	assign ch_ok  = (32'(channel) < CHANNEL_COUNT);

	// Classify: even parity and a known status code, or forced after retries.
	assign good       = ((^checked) == parity_bit)
		&& ((status == STATUS_OK_A) || (status == STATUS_OK_B));
	assign forced_now = (reject_q[ch_idx] >= retry_limit);
	assign take       = accept && ch_ok && (forced_now || good);

	assign push            = take;
	assign push_data.angle = checked[CHK_W-1 -: ANGLE_W];
	assign push_data.channel = channel;
	assign push_data.forced  = forced_now;

	// Per-channel count of dropped frames since the last taken one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				reject_q[i] <= '0;
			end
		end else if (accept && ch_ok) begin
			if (forced_now || good) begin
				reject_q[ch_idx] <= '0;
			end else begin
				reject_q[ch_idx] <= reject_q[ch_idx] + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/efcp_back.sv =====
`timescale 1ns / 1ps

module efcp_back
	import efcp_pkg::*;
#(
	parameter int SAMPLES_PER_PICK = 3,
	parameter int CHANNEL_COUNT    = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  sample_t            sample,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ANGLE_W-1:0] angle,
	output logic               out_channel,
	output logic               forced
);

	localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int CNT_W    = $clog2(SAMPLES_PER_PICK + 1);

	logic [ANGLE_W-1:0]  last_q      [CHANNEL_COUNT];
	logic [ANGLE_W-1:0]  best_q      [CHANNEL_COUNT];
	logic [ANGLE_W-1:0]  best_dist_q [CHANNEL_COUNT];
	logic [CNT_W-1:0]    count_q     [CHANNEL_COUNT];
	logic                forced_seen_q [CHANNEL_COUNT];

	logic                out_valid_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic                out_channel_q;
	logic                forced_q;

	logic [CH_IDX_W-1:0] ch_idx;
	logic [ANGLE_W-1:0]  diff;
	logic [ANGLE_W-1:0]  gap;
	logic                first;
	logic                closer;
	logic                closing;
	logic [ANGLE_W-1:0]  best_next;
	logic [ANGLE_W-1:0]  best_dist_next;
	logic                forced_any;

	assign ch_idx = CH_IDX_W'(sample.channel);

	// Wrapped distance from the sample to the channel's last picked angle.
	assign diff = sample.angle - last_q[ch_idx];
	assign gap  = (diff > HALF_TURN) ? (ANGLE_W'(0) - diff) : diff;

	// Running minimum; a tie keeps the earlier sample.
	assign first          = (count_q[ch_idx] == '0);
	assign closer         = first || (gap < best_dist_q[ch_idx]);
	assign best_next      = closer ? sample.angle : best_q[ch_idx];
	assign best_dist_next = closer ? gap : best_dist_q[ch_idx];
	assign closing        = (count_q[ch_idx] == CNT_W'(SAMPLES_PER_PICK - 1));
	assign forced_any     = forced_seen_q[ch_idx] | sample.forced;

	// A sample that completes a pick waits for room in the output register.
	assign pop = avail && (!closing || !out_valid_q || out_ready);

	// Per-channel gathering state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				last_q[i]        <= '0;
				count_q[i]       <= '0;
				forced_seen_q[i] <= 1'b0;
			end
		end else if (pop) begin
			if (closing) begin
				last_q[ch_idx]        <= best_next;
				count_q[ch_idx]       <= '0;
				forced_seen_q[ch_idx] <= 1'b0;
			end else begin
				count_q[ch_idx]       <= count_q[ch_idx] + 1'b1;
				forced_seen_q[ch_idx] <= forced_any;
			end
		end
	end

	// Running best of the current group; always written before it is read.
	always_ff @(posedge clk) begin
		if (pop) begin
			best_q[ch_idx]      <= best_next;
			best_dist_q[ch_idx] <= best_dist_next;
		end
	end

	// Output register holds a pick until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && closing) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && closing) begin
			angle_q       <= best_next;
			out_channel_q <= sample.channel;
			forced_q      <= forced_any;
		end
	end

	assign out_valid   = out_valid_q;
	assign angle       = angle_q;
	assign out_channel = out_channel_q;
	assign forced      = forced_q;

endmodule

// ===== hw/rtl/encoder_frame_check_and_pick.sv =====
`timescale 1ns / 1ps

// Encoder frame check and pick. Each input beat is one raw three-byte angle
// frame for one encoder channel. A frame with bad parity or an unknown status
// is dropped; after retry_limit drops on a channel the next frame is taken
// unchecked and the pick it joins is flagged as forced. Every
// SAMPLES_PER_PICK taken frames of a channel produce one output beat: the
// angle nearest (modulo one turn) to that channel's previous pick, the
// earlier one on a tie. The block takes one frame per clock while the queue
// has room. A pick reaches the output through two registers: the completing
// frame enters the two-entry queue, then the combinational distance compare
// loads the output register from the queue head. While a pick waits in the
// output register, a frame that would complete another pick stays at the
// head of the queue, and input stops once both queue entries are full.
// retry_limit resets to 4 and is written through cfg_we and cfg_wdata; the
// user must write it only while the block is idle; nothing enforces this.
module encoder_frame_check_and_pick
	import efcp_pkg::*;
#(
	parameter int SAMPLES_PER_PICK = 3,
	parameter int CHANNEL_COUNT    = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [RETRY_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         frame_byte_hi,
	input  logic [7:0]         frame_byte_mid,
	input  logic [7:0]         frame_byte_lo,
	input  logic               channel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ANGLE_W-1:0] angle,
	output logic               out_channel,
	output logic               forced
);

	logic [RETRY_W-1:0] retry_limit_q;
	logic               q_full;
	logic               q_push;
	sample_t            q_push_data;
	logic               q_pop;
	logic               q_avail;
	sample_t            q_head;

	// Retry limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
		end else if (cfg_we) begin
			retry_limit_q <= cfg_wdata;
		end
	end

	assign in_ready = !q_full;

	efcp_front #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.retry_limit    (retry_limit_q),
		.accept         (in_valid && in_ready),
		.frame_byte_hi  (frame_byte_hi),
		.frame_byte_mid (frame_byte_mid),
		.frame_byte_lo  (frame_byte_lo),
		.channel        (channel),
		.push           (q_push),
		.push_data      (q_push_data)
	);

	efcp_fifo #(
		.DEPTH (2)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.head      (q_head)
	);

	efcp_back #(
		.SAMPLES_PER_PICK (SAMPLES_PER_PICK),
		.CHANNEL_COUNT    (CHANNEL_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (q_avail),
		.sample      (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.angle       (angle),
		.out_channel (out_channel),
		.forced      (forced)
	);

endmodule
